[rtl/sdlm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdlm_pkg
// Shared types and constants for the stereo decimator / level meter.
// ----------------------------------------------------------------------------
package sdlm_pkg;

    localparam int MAX_DECIMATION_LOG2_DEF = 6;

    // Register reset values; floor, gain, level and peak values are Q1.15
    localparam logic [2:0]  DECIM_LOG2_RST  = 3'd0;
    localparam logic [15:0] LEVEL_FLOOR_RST = 16'd9830;
    localparam logic [15:0] LEVEL_GAIN_RST  = 16'd22938;
    localparam logic [15:0] LEVEL_RST       = 16'd32768;
    localparam logic signed [15:0] PEAK_RST = 16'sh8000;
    localparam logic [16:0] LEVEL_ONE       = 17'd32768;

    // Register map, word index on paddr[3:2]
    localparam logic [1:0] REG_DECIM_LOG2  = 2'd0;
    localparam logic [1:0] REG_LEVEL_FLOOR = 2'd1;
    localparam logic [1:0] REG_LEVEL_GAIN  = 2'd2;

    // Result of the accumulate stage handed to the level stage
    typedef struct packed {
        logic signed [15:0] wave;
        logic signed [15:0] peak;
        logic               buf_end;
    } t_mid;

endpackage : sdlm_pkg
`default_nettype wire

[rtl/sdlm_accum.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdlm_accum
// Input register, mono downmix, block sum/count, buffer peak and the
// registered hand-off of each emitted block to the level stage.
// ----------------------------------------------------------------------------
module sdlm_accum
    import sdlm_pkg::*;
#(
    parameter int MAX_DECIMATION_LOG2 = MAX_DECIMATION_LOG2_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [15:0] i_left,
    input  wire  [15:0] i_right,
    input  wire         i_buf_end,
    input  wire  [2:0]  i_decim_log2,
    output logic        o_mid_valid,
    input  wire         i_mid_ready,
    output t_mid        o_mid
);

    localparam int SW  = 16 + MAX_DECIMATION_LOG2;
    localparam int CW  = MAX_DECIMATION_LOG2 + 1;
    localparam int SHW = (MAX_DECIMATION_LOG2 > 0) ? $clog2(MAX_DECIMATION_LOG2 + 1) : 1;

    logic                  r_in_valid;
    logic signed [15:0]    r_left;
    logic signed [15:0]    r_right;
    logic                  r_end;

    logic signed [SW-1:0]  r_sum;
    logic [CW-1:0]         r_count;
    logic signed [15:0]    r_peak;

    logic                  r_mid_valid;
    t_mid                  r_mid;

    logic [SHW-1:0]        shift;
    logic [CW-1:0]         blk_len;
    logic signed [16:0]    lr_sum;
    logic signed [15:0]    mono;
    logic signed [15:0]    n_peak;
    logic signed [SW-1:0]  n_sum;
    logic [CW-1:0]         n_count;
    logic signed [SW-1:0]  avg;
    logic                  emit;
    logic                  mid_adv;
    logic                  consume;

    always_comb begin
        if (int'(i_decim_log2) > MAX_DECIMATION_LOG2) begin
            shift = SHW'(MAX_DECIMATION_LOG2);
        end else begin
            shift = SHW'(i_decim_log2);
        end
        blk_len = CW'(1) << shift;
        lr_sum  = 17'(r_left) + 17'(r_right);
        mono    = lr_sum[16:1];
        n_peak  = (mono > r_peak) ? mono : r_peak;
        n_sum   = r_sum + SW'(mono);
        n_count = r_count + CW'(1);
        avg     = n_sum >>> shift;
        emit    = (n_count >= blk_len) || r_end;
    end

    assign mid_adv    = !r_mid_valid || i_mid_ready;
    assign consume    = r_in_valid && mid_adv;
    assign o_in_ready = !r_in_valid || mid_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_left  <= i_left;
            r_right <= i_right;
            r_end   <= i_buf_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_peak  <= PEAK_RST;
        end else if (consume) begin
            if (emit) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end
            r_peak <= r_end ? PEAK_RST : n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (mid_adv) begin
            r_mid_valid <= consume && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && emit) begin
            r_mid.wave    <= avg[15:0];
            r_mid.peak    <= n_peak;
            r_mid.buf_end <= r_end;
        end
    end

    assign o_mid_valid = r_mid_valid;
    assign o_mid       = r_mid;

endmodule : sdlm_accum
`default_nettype wire

[rtl/sdlm_level.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdlm_level
// Smoothed level update on buffer ends and the result output register.
// ----------------------------------------------------------------------------
module sdlm_level
    import sdlm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_mid_valid,
    output logic        o_mid_ready,
    input  t_mid        i_mid,
    input  wire  [15:0] i_level_floor,
    input  wire  [15:0] i_level_gain,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [15:0] o_wave,
    output logic [15:0] o_level,
    output logic        o_updated
);

    logic               r_out_valid;
    logic [15:0]        r_wave;
    logic [15:0]        r_out_level;
    logic               r_updated;
    logic [15:0]        r_level;

    logic signed [16:0] gain_s;
    logic signed [32:0] prod;
    logic signed [17:0] scaled;
    logic signed [18:0] floor_s;
    logic signed [18:0] target;
    logic signed [18:0] lo_clamp;
    logic [16:0]        clamped;
    logic [17:0]        lvl_sum;
    logic [15:0]        n_level;
    logic               take;

    always_comb begin
        gain_s   = signed'({1'b0, i_level_gain});
        prod     = gain_s * i_mid.peak;
        scaled   = signed'(prod[32:15]);
        floor_s  = signed'({3'b000, i_level_floor});
        target   = floor_s + 19'(scaled);
        lo_clamp = (target < floor_s) ? floor_s : target;
        clamped  = (lo_clamp > 19'sd32768) ? LEVEL_ONE : lo_clamp[16:0];
        lvl_sum  = 18'(r_level) + 18'(clamped);
        n_level  = lvl_sum[16:1];
    end

    assign o_mid_ready = !r_out_valid || i_out_ready;
    assign take        = i_mid_valid && o_mid_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_level     <= LEVEL_RST;
        end else begin
            if (o_mid_ready) begin
                r_out_valid <= i_mid_valid;
            end
            if (take && i_mid.buf_end) begin
                r_level <= n_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_wave      <= i_mid.wave;
            r_out_level <= i_mid.buf_end ? n_level : r_level;
            r_updated   <= i_mid.buf_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_wave      = r_wave;
    assign o_level     = r_out_level;
    assign o_updated   = r_updated;

endmodule : sdlm_level
`default_nettype wire

[rtl/stereo_decimator_level_meter_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_decimator_level_meter_unit
// Stereo-to-mono boxcar decimator with a buffer peak level meter.
// ----------------------------------------------------------------------------
// Accepts one stereo frame per clock while the output is not stalled. Frames
// pass through three registers (input, block accumulate, level/output) in that
// order. Throughput is one frame per cycle when not stalled and is set by the
// block accumulate and the one 17x16 multiply of the level update. Frames that
// neither fill a block nor end a buffer produce no result. Back-pressure on the
// output stalls the whole pipe; the input side keeps accepting while any stage
// has room. Registers are to be written only while the block is idle; the block
// itself does not enforce this.
module stereo_decimator_level_meter_unit
    import sdlm_pkg::*;
#(
    parameter int MAX_DECIMATION_LOG2 = MAX_DECIMATION_LOG2_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // stream in
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // [15:0] left_sample, [31:16] right_sample
    input  wire         s_axis_tlast,  // buffer_end
    // stream out
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [15:0] wave_sample, [31:16] level
    output logic        m_axis_tlast,  // level_updated
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0]  r_decim_log2;
    logic [15:0] r_level_floor;
    logic [15:0] r_level_gain;

    logic        wr_en;
    logic [1:0]  reg_idx;

    logic        mid_valid;
    logic        mid_ready;
    t_mid        mid;

    logic [15:0] out_wave;
    logic [15:0] out_level;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim_log2  <= DECIM_LOG2_RST;
            r_level_floor <= LEVEL_FLOOR_RST;
            r_level_gain  <= LEVEL_GAIN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DECIM_LOG2:  r_decim_log2  <= pwdata[2:0];
                REG_LEVEL_FLOOR: r_level_floor <= pwdata[15:0];
                REG_LEVEL_GAIN:  r_level_gain  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DECIM_LOG2:  prdata = {29'd0, r_decim_log2};
            REG_LEVEL_FLOOR: prdata = {16'd0, r_level_floor};
            REG_LEVEL_GAIN:  prdata = {16'd0, r_level_gain};
            default:         prdata = 32'd0;
        endcase
    end

    sdlm_accum #(
        .MAX_DECIMATION_LOG2 (MAX_DECIMATION_LOG2)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_left       (s_axis_tdata[15:0]),
        .i_right      (s_axis_tdata[31:16]),
        .i_buf_end    (s_axis_tlast),
        .i_decim_log2 (r_decim_log2),
        .o_mid_valid  (mid_valid),
        .i_mid_ready  (mid_ready),
        .o_mid        (mid)
    );

    sdlm_level u_level (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mid_valid   (mid_valid),
        .o_mid_ready   (mid_ready),
        .i_mid         (mid),
        .i_level_floor (r_level_floor),
        .i_level_gain  (r_level_gain),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_wave        (out_wave),
        .o_level       (out_level),
        .o_updated     (m_axis_tlast)
    );

    assign m_axis_tdata = {out_level, out_wave};

endmodule : stereo_decimator_level_meter_unit
`default_nettype wire

[rtl/sdlm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdlm_checker
// Port-level checks for the stereo decimator / level meter.
// ----------------------------------------------------------------------------
module sdlm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire        m_axis_tlast
);

    // a stalled result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    // level never exceeds 1.0
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:16] <= 16'd32768))
        else $error("level above 1.0");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // level only moves on items that close a buffer
    a_level_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1
            m_axis_tvalid && !m_axis_tlast |->
            m_axis_tdata[31:16] == $past(m_axis_tdata[31:16]))
        else $error("level changed without a buffer end");

endmodule : sdlm_checker

bind stereo_decimator_level_meter_unit sdlm_checker u_sdlm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
